// File: hdl/bsde_pkg.sv
// ----------------------------------------------------------------------------
// bsde_pkg
// Shared types for the bitmap square draw engine: command codes and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bsde_pkg;

   typedef enum logic [1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_FILL   = 2'd1,
      ACT_HOLLOW = 2'd2,
      ACT_READ   = 2'd3
   } action_type;

   localparam int BYTE_BITS = 8;

   typedef struct packed {
      logic load;
      logic setup;
      logic rd_en;
      logic wr_en;
      logic advance;
      logic clr_step;
      logic peek;
      logic finish_load;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic span_last;
      logic clr_last;
      logic rsp_free;
   } status_type;

endpackage

// File: hdl/bsde_ctrl.sv
// ----------------------------------------------------------------------------
// bsde_ctrl
// Controller state machine: sequences clear sweeps, read-modify-write passes
// over the clipped square, pixel reads and result hand-off.
// ----------------------------------------------------------------------------
module bsde_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_action,
   output logic                  req_stall,
   input  bsde_pkg::status_type  status,
   output bsde_pkg::cmd_type     cmd
);

   typedef enum logic [7:0] {
      ST_INIT   = 8'b0000_0001,
      ST_IDLE   = 8'b0000_0010,
      ST_CLR    = 8'b0000_0100,
      ST_SETUP  = 8'b0000_1000,
      ST_RD     = 8'b0001_0000,
      ST_WR     = 8'b0010_0000,
      ST_PEEK   = 8'b0100_0000,
      ST_FINISH = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_INIT: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               case (bsde_pkg::action_type'(req_action))
                  bsde_pkg::ACT_CLEAR:  state_in = ST_CLR;
                  bsde_pkg::ACT_FILL:   state_in = ST_SETUP;
                  bsde_pkg::ACT_HOLLOW: state_in = ST_SETUP;
                  bsde_pkg::ACT_READ:   state_in = ST_PEEK;
                  default:              state_in = ST_IDLE;
               endcase
            end
         end
         ST_CLR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) state_in = ST_FINISH;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = status.empty ? ST_FINISH : ST_RD;
         end
         ST_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_WR;
         end
         ST_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.advance = 1'b1;
            state_in    = status.span_last ? ST_FINISH : ST_RD;
         end
         ST_PEEK: begin
            cmd.rd_en = 1'b1;
            cmd.peek  = 1'b1;
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.finish_load = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hdl/bsde_dpath.sv
// ----------------------------------------------------------------------------
// bsde_dpath
// Datapath: frame store memory, command registers, clipping bounds, row and
// byte walkers, pixel mask generation and the result register.
// ----------------------------------------------------------------------------
module bsde_dpath #(
   parameter int WIDTH  = 64,
   parameter int HEIGHT = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            req_action,
   input  logic signed [6:0]     req_x_pos,
   input  logic signed [6:0]     req_y_pos,
   input  logic [6:0]            req_side_length,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output logic                  rsp_pixel_value,
   output logic                  rsp_was_read,
   input  bsde_pkg::cmd_type     cmd,
   output bsde_pkg::status_type  status
);

   localparam int ROW_BYTES = (WIDTH + 7) / 8;
   localparam int STORE     = ROW_BYTES * HEIGHT;
   localparam int AW        = (STORE > 1) ? $clog2(STORE) : 1;
   localparam int BW        = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
   localparam int DIM       = (WIDTH > HEIGHT) ? WIDTH : HEIGHT;
   localparam int CW        = (($clog2(DIM) > 8) ? $clog2(DIM) : 8) + 2;
   localparam int BB        = bsde_pkg::BYTE_BITS;

   localparam logic signed [CW-1:0] XMAX = CW'(WIDTH - 1);
   localparam logic signed [CW-1:0] YMAX = CW'(HEIGHT - 1);
   localparam logic signed [CW-1:0] ZERO = '0;

   logic [BB-1:0] mem [STORE];

   bsde_pkg::action_type  act_ff;
   logic signed [6:0]     x0_ff;
   logic signed [6:0]     y0_ff;
   logic [6:0]            side_ff;

   logic signed [CW-1:0]  xlo_ff, xhi_ff, yhi_ff, row_ff;
   logic [BW-1:0]         blo_ff, bhi_ff, byte_ff;
   logic [AW-1:0]         base_ff, clr_ff;
   logic [BB-1:0]         rdata_ff;
   logic                  in_ok_ff;
   logic [2:0]            bit_ff;
   logic                  rsp_valid_ff, rsp_pixel_ff, rsp_read_ff;

   logic signed [CW-1:0]  x0s, y0s, side_s, xr, yb, xlo, xhi, ylo, yhi;
   logic                  empty, in_ok, byte_last, row_last, edge_row, fill;
   logic [AW-1:0]         rmw_addr, peek_addr, rd_addr;
   logic [BB-1:0]         mask;

   assign x0s    = CW'(x0_ff);
   assign y0s    = CW'(y0_ff);
   assign side_s = CW'(side_ff);
   assign xr     = x0s + side_s - CW'(1);
   assign yb     = y0s + side_s - CW'(1);
   assign xlo    = (x0s < ZERO) ? ZERO : x0s;
   assign xhi    = (xr > XMAX) ? XMAX : xr;
   assign ylo    = (y0s < ZERO) ? ZERO : y0s;
   assign yhi    = (yb > YMAX) ? YMAX : yb;
   assign empty  = (side_ff == 7'd0) || (xr < ZERO) || (x0s > XMAX) ||
                   (yb < ZERO) || (y0s > YMAX);
   assign in_ok  = (x0s >= ZERO) && (x0s <= XMAX) && (y0s >= ZERO) && (y0s <= YMAX);

   assign byte_last = (byte_ff == bhi_ff);
   assign row_last  = (row_ff == yhi_ff);
   assign edge_row  = (row_ff == y0s) || (row_ff == yb);
   assign fill      = (act_ff == bsde_pkg::ACT_FILL);

   assign rmw_addr  = base_ff + AW'(byte_ff);
   assign peek_addr = AW'($unsigned(y0s)) * AW'(ROW_BYTES) + AW'($unsigned(x0s >>> 3));
   assign rd_addr   = cmd.peek ? peek_addr : rmw_addr;

   always_comb begin
      logic signed [CW-1:0] col;
      mask = '0;
      col  = '0;
      for (int i = 0; i < BB; i++) begin
         col = CW'({byte_ff, 3'(i)});
         mask[BB-1-i] = (col >= xlo_ff) && (col <= xhi_ff) &&
                        (fill || edge_row || (col == x0s) || (col == xr));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_step) begin
         mem[clr_ff] <= '0;
      end else if (cmd.wr_en) begin
         mem[rmw_addr] <= rdata_ff | mask;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff  <= bsde_pkg::action_type'(req_action);
         x0_ff   <= req_x_pos;
         y0_ff   <= req_y_pos;
         side_ff <= req_side_length;
      end
      if (cmd.setup) begin
         xlo_ff  <= xlo;
         xhi_ff  <= xhi;
         yhi_ff  <= yhi;
         blo_ff  <= xlo[BW+2:3];
         bhi_ff  <= xhi[BW+2:3];
         byte_ff <= xlo[BW+2:3];
         row_ff  <= ylo;
         base_ff <= AW'($unsigned(ylo)) * AW'(ROW_BYTES);
      end else if (cmd.advance) begin
         if (byte_last) begin
            byte_ff <= blo_ff;
            row_ff  <= row_ff + CW'(1);
            base_ff <= base_ff + AW'(ROW_BYTES);
         end else begin
            byte_ff <= byte_ff + BW'(1);
         end
      end
      if (cmd.peek) begin
         in_ok_ff <= in_ok;
         bit_ff   <= x0_ff[2:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.load) begin
         clr_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_ff <= clr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish_load) begin
         rsp_read_ff  <= (act_ff == bsde_pkg::ACT_READ);
         rsp_pixel_ff <= (act_ff == bsde_pkg::ACT_READ) && in_ok_ff &&
                         rdata_ff[3'd7 - bit_ff];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_value = rsp_pixel_ff;
   assign rsp_was_read    = rsp_read_ff;

   assign status.empty     = empty;
   assign status.span_last = byte_last && row_last;
   assign status.clr_last  = (clr_ff == AW'(STORE - 1));
   assign status.rsp_free  = !rsp_valid_ff || !rsp_stall;

   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> $past(cmd.rd_en))
      else $error("modify write without a preceding read");

   a_read_spacing: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |=> !cmd.rd_en)
      else $error("back to back memory reads");

   a_pixel_only_on_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_read_ff) |-> !rsp_pixel_ff)
      else $error("pixel set on a non-read result");

endmodule

// File: hdl/bitmap_square_draw_engine.sv
// ----------------------------------------------------------------------------
// bitmap_square_draw_engine
// Operation: clear zeroes all ROW_BYTES*HEIGHT bytes; a square does one
// memory read-modify-write per touched byte; read does one memory read.
// Requests: one transaction at a time; req_stall is high unless idle.
// Reset: a clearing pass over all ROW_BYTES*HEIGHT bytes (512 at defaults)
// zeroes the frame store; req_stall stays high until it completes.
// ----------------------------------------------------------------------------
module bitmap_square_draw_engine #(
   parameter int WIDTH  = 64,
   parameter int HEIGHT = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_action,
   input  logic signed [6:0] req_x_pos,
   input  logic signed [6:0] req_y_pos,
   input  logic [6:0]        req_side_length,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_pixel_value,
   output logic              rsp_was_read
);

   bsde_pkg::cmd_type    cmd;
   bsde_pkg::status_type status;

   bsde_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .status     (status),
      .cmd        (cmd)
   );

   bsde_dpath #(
      .WIDTH  (WIDTH),
      .HEIGHT (HEIGHT)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_action      (req_action),
      .req_x_pos       (req_x_pos),
      .req_y_pos       (req_y_pos),
      .req_side_length (req_side_length),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_pixel_value (rsp_pixel_value),
      .rsp_was_read    (rsp_was_read),
      .cmd             (cmd),
      .status          (status)
   );

endmodule
